@@ design/r2fft_pkg.sv @@
// Package for the radix-2 in-place FFT: twiddle quarter-wave ROM.
// No dependencies.
package r2fft_pkg;
    localparam int ROM_LOG2 = 6;
    localparam int QUARTER = 16;
    typedef logic signed [15:0] t_tw;

    function automatic t_tw quarter_cos(input logic [4:0] k);
        case (k)
            5'd0: return 16'sd32767;   5'd1: return 16'sd32610;
            5'd2: return 16'sd32138;   5'd3: return 16'sd31357;
            5'd4: return 16'sd30274;   5'd5: return 16'sd28899;
            5'd6: return 16'sd27246;   5'd7: return 16'sd25330;
            5'd8: return 16'sd23170;   5'd9: return 16'sd20788;
            5'd10: return 16'sd18205;  5'd11: return 16'sd15447;
            5'd12: return 16'sd12540;  5'd13: return 16'sd9512;
            5'd14: return 16'sd6393;   5'd15: return 16'sd3212;
            default: return 16'sd0;
        endcase
    endfunction
endpackage

@@ design/r2fft_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module r2fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/radix2_fft_in_place_top.sv @@
// Radix-2 in-place FFT top level: loader, butterfly sequencer, bin readout. Uses r2fft_pkg, r2fft_ram.
// Loading accepts one sample per cycle; input stalls while a config transaction is offered.
// After the N-th sample each butterfly runs through its steps on the shared unit (two store
// reads, multiply, round/add, two writes); then the bins are read out, each store read issued
// only once the previous one has landed, unless stalled. Input is stalled from block completion to the last bin.
// Synchronous active-low reset: log2_points = min(log2(MAX_POINTS), 6), load count 0.
module radix2_fft_in_place_top
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS+5:0] o_bin_real,
    output logic signed [SAMPLE_BITS+5:0] o_bin_imag,
    output logic                          o_last_bin,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_data
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int BW = SAMPLE_BITS + 6;
    localparam int PW = 2 * BW;
    localparam int MW = BW + 17;
    localparam logic [2:0] LIM = (AW > 6) ? 3'd6 : 3'(AW);
    localparam logic signed [BW-1:0] BMAX = {1'b0, {(BW-1){1'b1}}};
    localparam logic signed [BW-1:0] BMIN = {1'b1, {(BW-1){1'b0}}};

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_WRA  = 3'd5;
    localparam logic [2:0] S_WRB  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_lg;
    logic [AW:0] r_cnt;
    logic [2:0]  r_stage;
    logic [AW-1:0] r_bf;
    logic [AW:0] r_ocnt;
    logic        r_rd_pend;
    logic signed [BW-1:0] r_br, r_bi, r_ar, r_ai;
    logic signed [BW:0]   r_pr, r_pi;
    logic signed [MW-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [15:0]   r_c, r_s;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0] ram_wdata, ram_rdata;

    r2fft_ram #(.WIDTH(PW), .DEPTH(1 << AW)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // butterfly addressing: dd = N >> stage, group g = bf / dd, m = bf % dd
    logic [AW:0]   npts;
    logic [AW-1:0] half_mask, dd, mmask, ia, ib, grp, trev;
    logic [4:0]    tk5;
    logic [AW-1:0] orev;

    always_comb begin
        npts = (AW+1)'(1) << r_lg;
        half_mask = AW'((npts >> 1) - 1);
        dd = AW'(npts >> r_stage);
        mmask = dd - AW'(1);
        grp = AW'(r_bf >> (r_lg - r_stage));
        ia = AW'((grp << (r_lg - r_stage + 3'd1)) | (r_bf & mmask));
        ib = ia + dd;
        trev = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(r_lg) - 1) begin
                trev[i] = grp[int'(r_lg) - 2 - i];
            end
        end
        tk5 = 5'(trev << (3'(ROM_LOG2) - r_lg));
        orev = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(r_lg)) begin
                orev[i] = r_ocnt[int'(r_lg) - 1 - i];
            end
        end
    end

    logic signed [15:0] tw_c, tw_s;
    always_comb begin
        if (tk5 <= 5'(QUARTER)) begin
            tw_c = quarter_cos(tk5);
            tw_s = quarter_cos(5'(QUARTER) - tk5);
        end else begin
            tw_c = -quarter_cos(5'd0 - tk5);
            tw_s = quarter_cos(tk5 - 5'(QUARTER));
        end
    end

    // twiddle product can exceed the bin range; keep one extra bit
    function automatic logic signed [BW:0] rnd(input logic signed [MW:0] v);
        logic signed [MW:0] t;
        t = (v + (MW+1)'(16384)) >>> 15;
        return (BW+1)'(t);
    endfunction

    function automatic logic signed [BW-1:0] sat(input logic signed [BW+1:0] v);
        if (v > (BW+2)'(BMAX)) return BMAX;
        if (v < (BW+2)'(BMIN)) return BMIN;
        return BW'(v);
    endfunction

    logic in_acc, out_acc, last_bf, last_stage;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_LOAD) || cfg_valid;
    assign cfg_ready = (r_state == S_LOAD);
    assign last_bf = (r_bf == half_mask);
    assign last_stage = (r_stage == r_lg);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = AW'(r_cnt);
        ram_wdata = {BW'(i_sample_real), BW'(i_sample_imag)};
        ram_raddr = ib;
        unique case (r_state) inside
            S_LOAD: ram_we = in_acc;
            S_RDB, S_MUL, S_ADD: ram_raddr = ib;
            S_RDA: ram_raddr = ia;
            S_WRA: begin
                ram_we = 1'b1;
                ram_waddr = ia;
                ram_wdata = {sat((BW+2)'(r_ar) + (BW+2)'(r_pr)),
                             sat((BW+2)'(r_ai) + (BW+2)'(r_pi))};
            end
            S_WRB: begin
                ram_we = 1'b1;
                ram_waddr = ib;
                ram_wdata = {sat((BW+2)'(r_ar) - (BW+2)'(r_pr)),
                             sat((BW+2)'(r_ai) - (BW+2)'(r_pi))};
            end
            S_OUT: ram_raddr = orev;
            default: ram_raddr = ib;
        endcase
    end

    // output skid: RAM read issued when the output register is free or leaving
    logic out_free, rd_issue;
    assign out_free = !o_valid || out_acc;
    assign rd_issue = (r_state == S_OUT) && (r_ocnt < npts) && !r_rd_pend &&
                      out_free && !(o_valid && !out_acc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (in_acc && (r_cnt + 1'b1 == npts)) n_state = S_RDB;
            S_RDB: n_state = S_RDA;
            S_RDA: n_state = S_MUL;
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_WRA;
            S_WRA: n_state = S_WRB;
            S_WRB: n_state = (last_bf && last_stage) ? S_OUT : S_RDB;
            S_OUT: if (out_acc && o_last_bin) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lg <= LIM;
            r_cnt <= '0;
            r_stage <= 3'd1;
            r_bf <= '0;
            r_ocnt <= '0;
            r_rd_pend <= 1'b0;
            o_valid <= 1'b0;
            o_last_bin <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_valid && cfg_ready) begin
                r_lg <= (cfg_data == 3'd0) ? 3'd1 : (cfg_data > LIM) ? LIM : cfg_data;
                r_cnt <= '0;
            end else if (in_acc) begin
                r_cnt <= (n_state == S_RDB) ? '0 : r_cnt + 1'b1;
            end
            if (in_acc && n_state == S_RDB) begin
                r_stage <= 3'd1;
                r_bf <= '0;
            end
            if (r_state == S_WRB) begin
                r_bf <= last_bf ? '0 : r_bf + 1'b1;
                if (last_bf) r_stage <= r_stage + 3'd1;
                r_ocnt <= '0;
            end
            r_rd_pend <= rd_issue;
            if (rd_issue) r_ocnt <= r_ocnt + 1'b1;
            if (r_rd_pend) begin
                o_valid <= 1'b1;
                o_last_bin <= (r_ocnt == npts);
            end else if (out_acc) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDA) begin
            r_br <= ram_rdata[PW-1:BW];
            r_bi <= ram_rdata[BW-1:0];
            r_c <= tw_c;
            r_s <= tw_s;
        end
        if (r_state == S_MUL) begin
            r_ar <= ram_rdata[PW-1:BW];
            r_ai <= ram_rdata[BW-1:0];
            r_m0 <= MW'(r_br) * MW'(r_c);
            r_m1 <= MW'(r_bi) * MW'(r_s);
            r_m2 <= MW'(r_bi) * MW'(r_c);
            r_m3 <= MW'(r_br) * MW'(r_s);
        end
        if (r_state == S_ADD) begin
            r_pr <= rnd((MW+1)'(r_m0) + (MW+1)'(r_m1));
            r_pi <= rnd((MW+1)'(r_m2) - (MW+1)'(r_m3));
        end
        if (r_rd_pend) begin
            o_bin_real <= ram_rdata[PW-1:BW];
            o_bin_imag <= ram_rdata[BW-1:0];
        end
    end

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !in_acc) else $error("input taken while busy");
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_bin) |-> (r_state == S_OUT)) else $error("stray last bin");
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("output outside readout");
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < npts) else $error("load count overrun");
endmodule
